[hw/rtl/lwge_pkg.sv]
// Shared constants, codes and types of the LED wave gradient engine.
package lwge_pkg;

    localparam int MAX_LEDS   = 256;
    localparam int MAX_WAVES  = 4;
    localparam int MAX_POINTS = 16;

    localparam int LED_AW = $clog2(MAX_LEDS);
    localparam int WAVE_W = $clog2(MAX_WAVES);
    localparam int PT_W   = $clog2(MAX_POINTS);
    localparam int TAB_AW = WAVE_W + PT_W;

    // Largest colour value, 255.0 in unsigned 8.8.
    localparam logic [15:0] COLOUR_MAX = 16'hFF00;

    // Width of the divider's dividend and quotient.
    localparam int DIV_W  = 33;
    localparam int DIV_NW = 6;

    // Request kinds.
    localparam logic [2:0] KIND_DEFINE = 3'd0;
    localparam logic [2:0] KIND_LOAD   = 3'd1;
    localparam logic [2:0] KIND_START  = 3'd2;
    localparam logic [2:0] KIND_TICK   = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    // Result status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // Register word indexes on the configuration port.
    localparam logic REG_LED_COUNT = 1'b0;

    // Gradient point: red, green, blue and duration.
    typedef struct packed {
        logic [7:0]       dur;
        logic [2:0][7:0]  col;
    } pt_t;

    // Per-point step widths, signed 9.8.
    typedef logic [2:0][16:0] slope_t;

    // One LED: colours in unsigned 8.8, current point and step counter.
    typedef struct packed {
        logic [7:0]        steps;
        logic [PT_W-1:0]   cur;
        logic [2:0][15:0]  col;
    } led_t;

    // Divider request and response.
    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] nbits;
        logic [DIV_W-1:0]  dividend;
        logic [8:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quot;
        logic [8:0]        rem;
    } div_rsp_t;

endpackage

[hw/rtl/led_wave_gradient_engine.sv]
// Top level of the LED wave gradient engine: request sequencer, tables and LED store.
//
// Each input word is one request; each request returns exactly one result word.
// Define, load point (not last), read and an ignored tick finish without the divider.
// A tick walks the LED store one entry at a time, bound by the single read port of
// the point table. Starting a wave (or loading its last point) first computes the
// step widths with the shared bit-serial divider, then seeds every LED in use
// through the same divider. The LED store resets to zero through one valid bit per
// entry, so no clearing pass is needed. The next request is taken while a finished
// result still waits on the output.
module led_wave_gradient_engine
    import lwge_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // wave_index[1:0], point_index[5:2], point_count[10:6], wave_width[19:11],
    // red[27:20], green[35:28], blue[43:36], duration[51:44], led_index[59:52]
    input  logic [63:0] s_tdata,
    // kind[2:0]
    input  logic [2:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [23:0] m_tdata,
    // status[0]
    output logic [0:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [27:0] {
        ST_IDLE      = 28'h0000001,
        ST_DONE      = 28'h0000002,
        ST_RD_WAIT   = 28'h0000004,
        ST_DIV_WAIT  = 28'h0000008,
        ST_SL_A      = 28'h0000010,
        ST_SL_B      = 28'h0000020,
        ST_SL_C      = 28'h0000040,
        ST_SL_DIV    = 28'h0000080,
        ST_SL_RES    = 28'h0000100,
        ST_SL_WR     = 28'h0000200,
        ST_SL_END    = 28'h0000400,
        ST_PER1      = 28'h0000800,
        ST_PER2      = 28'h0001000,
        ST_PER3      = 28'h0002000,
        ST_SD_IDX    = 28'h0004000,
        ST_SD_IDXC   = 28'h0008000,
        ST_SD_T      = 28'h0010000,
        ST_SD_TDIV   = 28'h0020000,
        ST_SD_STEPS  = 28'h0040000,
        ST_SD_OFF    = 28'h0080000,
        ST_SD_OFFDIV = 28'h0100000,
        ST_SD_COL    = 28'h0200000,
        ST_SD_WR     = 28'h0400000,
        ST_TK_RD     = 28'h0800000,
        ST_TK_LED    = 28'h1000000,
        ST_TK_PT     = 28'h2000000,
        ST_TK_NEXT   = 28'h4000000,
        ST_TK_WR     = 28'h8000000
    } state_t;

    // Input word fields.
    logic [WAVE_W-1:0] in_wave;
    logic [PT_W-1:0]   in_point;
    logic [4:0]        in_count;
    logic [8:0]        in_width;
    logic [7:0]        in_red;
    logic [7:0]        in_green;
    logic [7:0]        in_blue;
    logic [7:0]        in_dur;
    logic [LED_AW-1:0] in_led;

    assign in_wave  = s_tdata[1:0];
    assign in_point = s_tdata[5:2];
    assign in_count = s_tdata[10:6];
    assign in_width = s_tdata[19:11];
    assign in_red   = s_tdata[27:20];
    assign in_green = s_tdata[35:28];
    assign in_blue  = s_tdata[43:36];
    assign in_dur   = s_tdata[51:44];
    assign in_led   = s_tdata[59:52];

    state_t state_reg;
    state_t ret_reg;

    logic [8:0]        led_count_reg;
    logic [4:0]        shape_count_reg [MAX_WAVES];
    logic [8:0]        shape_width_reg [MAX_WAVES];
    logic [WAVE_W-1:0] active_reg;
    logic              ready_reg;

    logic [WAVE_W-1:0] work_w_reg;
    logic [8:0]        i_reg;
    logic [1:0]        k_reg;
    logic [7:0]        pos_reg;
    logic [8:0]        per_reg;
    pt_t               a_reg;
    pt_t               b_reg;
    logic              neg_reg;
    slope_t            slope_reg;
    logic [PT_W-1:0]   idx_reg;
    logic [7:0]        rem_reg;
    pt_t               ptw_reg;
    slope_t            slw_reg;
    logic [15:0]       t_reg;
    logic [7:0]        steps_reg;
    logic [DIV_W-1:0]  prod_reg;
    led_t              led_reg;

    logic              res_status_reg;
    logic [2:0][7:0]   res_col_reg;
    logic              m_valid_reg;
    logic              m_status_reg;
    logic [23:0]       m_data_reg;

    // Memories and their registered read data.
    pt_t               point_mem [MAX_WAVES*MAX_POINTS];
    slope_t            slope_mem [MAX_WAVES*MAX_POINTS];
    led_t              led_mem   [MAX_LEDS];
    logic [MAX_LEDS-1:0] led_valid_reg;
    pt_t               pt_q_reg;
    slope_t            sl_q_reg;
    led_t              led_q_reg;
    logic              led_vq_reg;
    led_t              led_eff;

    logic [TAB_AW-1:0] pt_rd_addr;
    logic [TAB_AW-1:0] sl_rd_addr;
    logic [LED_AW-1:0] led_rd_addr;
    logic              pt_we;
    logic [TAB_AW-1:0] pt_wr_addr;
    pt_t               pt_wr_data;
    logic              sl_we;
    logic              led_we;
    led_t              led_wr_data;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic              in_acc;
    logic [8:0]        n_eff;
    logic [4:0]        p_cur;
    logic [8:0]        width_eff;
    logic              define_bad;
    logic              load_bad;
    logic [PT_W-1:0]   i_nxt_pt;
    logic              tk_valid;
    logic [7:0]        tk_dur;
    logic              tk_roll;
    logic [PT_W-1:0]   tk_nxt;
    logic [8:0]        diff_k;
    logic [7:0]        diff_mag;
    logic [16:0]       sl_mag;

    // Colour saturation to 0..255.0.
    function automatic logic [15:0] clamp_col(input logic signed [26:0] v);
        logic [15:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({11'b0, COLOUR_MAX})) begin
            r = COLOUR_MAX;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign n_eff    = (led_count_reg > 9'(MAX_LEDS)) ? 9'(MAX_LEDS) : led_count_reg;
    assign p_cur    = shape_count_reg[work_w_reg];
    assign width_eff = (shape_width_reg[work_w_reg] > n_eff) ? n_eff
                                                             : shape_width_reg[work_w_reg];

    // Request checks.
    assign define_bad = (in_count == '0) || (in_count > 5'(MAX_POINTS)) ||
                        (in_width == '0) || (in_width > 9'(MAX_LEDS));
    assign load_bad   = (shape_count_reg[in_wave] == '0) ||
                        ({1'b0, in_point} >= shape_count_reg[in_wave]) || (in_dur == '0);

    // Next point around the wave, for the slope pass.
    assign i_nxt_pt = (i_reg + 9'd1 == {4'b0, p_cur}) ? '0 : PT_W'(i_reg + 9'd1);

    // Per-LED tick terms.
    assign led_eff  = led_vq_reg ? led_q_reg : '0;
    assign tk_valid = ({1'b0, led_reg.cur} < p_cur);
    assign tk_dur   = tk_valid ? pt_q_reg.dur : 8'd0;
    assign tk_roll  = ({1'b0, led_reg.steps} + 9'd1 >= {1'b0, tk_dur});
    assign tk_nxt   = ({1'b0, led_reg.cur} + 5'd1 >= p_cur) ? '0 : led_reg.cur + 1'b1;

    // Slope pass operand: colour difference of this point to the next.
    assign diff_k   = {1'b0, b_reg.col[k_reg]} - {1'b0, a_reg.col[k_reg]};
    assign diff_mag = diff_k[8] ? 8'(-diff_k) : diff_k[7:0];
    assign sl_mag   = slw_reg[k_reg][16] ? 17'(-slw_reg[k_reg]) : slw_reg[k_reg];

    // Table read addresses.
    always_comb begin
        pt_rd_addr = {work_w_reg, PT_W'(0)};
        sl_rd_addr = {work_w_reg, PT_W'(0)};
        case (state_reg)
            ST_SL_A: begin
                pt_rd_addr = {work_w_reg, i_reg[PT_W-1:0]};
            end
            ST_SL_B: begin
                pt_rd_addr = {work_w_reg, i_nxt_pt};
            end
            ST_SD_IDXC: begin
                pt_rd_addr = {work_w_reg, div_rsp.quot[PT_W-1:0]};
                sl_rd_addr = {work_w_reg, div_rsp.quot[PT_W-1:0]};
            end
            ST_TK_LED: begin
                pt_rd_addr = {work_w_reg, led_eff.cur};
                sl_rd_addr = {work_w_reg, led_eff.cur};
            end
            ST_TK_PT: begin
                pt_rd_addr = {work_w_reg, tk_nxt};
            end
            default: begin
            end
        endcase
    end

    assign led_rd_addr = (state_reg == ST_TK_RD) ? i_reg[LED_AW-1:0] : in_led;

    // Point table writes come straight from a load request.
    assign pt_we            = in_acc && (s_tuser == KIND_LOAD) && !load_bad;
    assign pt_wr_addr       = {in_wave, in_point};
    assign pt_wr_data.dur   = in_dur;
    assign pt_wr_data.col   = {in_blue, in_green, in_red};
    assign sl_we            = (state_reg == ST_SL_WR);
    assign led_we           = (state_reg == ST_SD_WR) || (state_reg == ST_TK_WR);
    assign led_wr_data      = led_reg;

    always_ff @(posedge aclk) begin
        if (pt_we) begin
            point_mem[pt_wr_addr] <= pt_wr_data;
        end
        pt_q_reg <= point_mem[pt_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (sl_we) begin
            slope_mem[{work_w_reg, i_reg[PT_W-1:0]}] <= slope_reg;
        end
        sl_q_reg <= slope_mem[sl_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (led_we) begin
            led_mem[i_reg[LED_AW-1:0]] <= led_wr_data;
        end
        led_q_reg <= led_mem[led_rd_addr];
    end

    // Valid bits stand in for the zero reset of the LED store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_valid_reg <= '0;
            led_vq_reg    <= 1'b0;
        end else begin
            if (led_we) begin
                led_valid_reg[i_reg[LED_AW-1:0]] <= 1'b1;
            end
            led_vq_reg <= led_valid_reg[led_rd_addr];
        end
    end

    // Divider requests.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.nbits    = DIV_NW'(DIV_W);
        div_req.dividend = '0;
        div_req.divisor  = per_reg;
        case (state_reg)
            ST_SL_DIV: begin
                div_req.start    = (a_reg.dur != '0);
                div_req.nbits    = DIV_NW'(17);
                div_req.dividend = DIV_W'({1'b0, diff_mag, 8'b0} + {10'b0, a_reg.dur[7:1]});
                div_req.divisor  = {1'b0, a_reg.dur};
            end
            ST_PER1: begin
                div_req.start    = 1'b1;
                div_req.nbits    = DIV_NW'(9);
                div_req.dividend = DIV_W'(n_eff);
                div_req.divisor  = width_eff;
            end
            ST_PER2: begin
                div_req.start    = 1'b1;
                div_req.nbits    = DIV_NW'(9);
                div_req.dividend = DIV_W'(n_eff);
                div_req.divisor  = div_rsp.quot[8:0];
            end
            ST_SD_IDX: begin
                div_req.start    = 1'b1;
                div_req.nbits    = DIV_NW'(13);
                div_req.dividend = DIV_W'(pos_reg * p_cur);
            end
            ST_SD_TDIV: begin
                div_req.start    = 1'b1;
                div_req.nbits    = DIV_NW'(16);
                div_req.dividend = DIV_W'(t_reg);
            end
            ST_SD_OFFDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg + DIV_W'(per_reg[8:1]);
            end
            default: begin
            end
        endcase
    end

    lwge_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LED_COUNT) ? {23'b0, led_count_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg <= 9'(MAX_LEDS);
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_LED_COUNT) begin
            led_count_reg <= pwdata[8:0];
        end
    end

    // Request sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ret_reg    <= ST_IDLE;
            active_reg <= '0;
            ready_reg  <= 1'b0;
            for (int w = 0; w < MAX_WAVES; w++) begin
                shape_count_reg[w] <= '0;
                shape_width_reg[w] <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        res_status_reg <= STATUS_OK;
                        res_col_reg    <= '0;
                        i_reg          <= '0;
                        work_w_reg     <= in_wave;
                        state_reg      <= ST_DONE;
                        case (s_tuser)
                            KIND_DEFINE: begin
                                if (define_bad) begin
                                    res_status_reg <= STATUS_BAD;
                                end else begin
                                    shape_count_reg[in_wave] <= in_count;
                                    shape_width_reg[in_wave] <= in_width;
                                    if (in_wave == active_reg) begin
                                        ready_reg <= 1'b0;
                                    end
                                end
                            end
                            KIND_LOAD: begin
                                if (load_bad) begin
                                    res_status_reg <= STATUS_BAD;
                                end else if ({1'b0, in_point} + 5'd1
                                             == shape_count_reg[in_wave]) begin
                                    state_reg <= ST_SL_A;
                                end
                            end
                            KIND_START: begin
                                if (shape_count_reg[in_wave] == '0) begin
                                    res_status_reg <= STATUS_BAD;
                                end else begin
                                    state_reg <= ST_SL_A;
                                end
                            end
                            KIND_TICK: begin
                                work_w_reg <= active_reg;
                                if (ready_reg && n_eff != '0) begin
                                    state_reg <= ST_TK_RD;
                                end
                            end
                            KIND_READ: begin
                                if ({1'b0, in_led} >= n_eff) begin
                                    res_status_reg <= STATUS_BAD;
                                end else begin
                                    state_reg <= ST_RD_WAIT;
                                end
                            end
                            default: begin
                                res_status_reg <= STATUS_BAD;
                            end
                        endcase
                    end
                end

                ST_RD_WAIT: begin
                    for (int k = 0; k < 3; k++) begin
                        logic [16:0] rnd;
                        rnd = {1'b0, led_eff.col[k]} + 17'h80;
                        res_col_reg[k] <= rnd[16] ? 8'hFF : rnd[15:8];
                    end
                    state_reg <= ST_DONE;
                end

                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        state_reg <= ret_reg;
                    end
                end

                // Step widths of every point of the wave.
                ST_SL_A: begin
                    state_reg <= ST_SL_B;
                end
                ST_SL_B: begin
                    a_reg     <= pt_q_reg;
                    state_reg <= ST_SL_C;
                end
                ST_SL_C: begin
                    b_reg     <= pt_q_reg;
                    k_reg     <= '0;
                    state_reg <= ST_SL_DIV;
                end
                ST_SL_DIV: begin
                    if (a_reg.dur == '0) begin
                        slope_reg[k_reg] <= '0;
                        k_reg            <= k_reg + 1'b1;
                        state_reg        <= (k_reg == 2'd2) ? ST_SL_WR : ST_SL_DIV;
                    end else begin
                        neg_reg   <= diff_k[8];
                        ret_reg   <= ST_SL_RES;
                        state_reg <= ST_DIV_WAIT;
                    end
                end
                ST_SL_RES: begin
                    slope_reg[k_reg] <= neg_reg ? 17'(-div_rsp.quot[16:0]) : div_rsp.quot[16:0];
                    k_reg            <= k_reg + 1'b1;
                    state_reg        <= (k_reg == 2'd2) ? ST_SL_WR : ST_SL_DIV;
                end
                ST_SL_WR: begin
                    if (i_reg + 9'd1 == {4'b0, p_cur}) begin
                        state_reg <= ST_SL_END;
                    end else begin
                        i_reg     <= i_reg + 9'd1;
                        state_reg <= ST_SL_A;
                    end
                end
                ST_SL_END: begin
                    active_reg <= work_w_reg;
                    ready_reg  <= 1'b1;
                    state_reg  <= (n_eff == '0) ? ST_DONE : ST_PER1;
                end

                // Repetition length: n / (n / width).
                ST_PER1: begin
                    ret_reg   <= ST_PER2;
                    state_reg <= ST_DIV_WAIT;
                end
                ST_PER2: begin
                    ret_reg   <= ST_PER3;
                    state_reg <= ST_DIV_WAIT;
                end
                ST_PER3: begin
                    per_reg   <= div_rsp.quot[8:0];
                    i_reg     <= '0;
                    pos_reg   <= '0;
                    state_reg <= ST_SD_IDX;
                end

                // Seed the phase of every LED in use.
                ST_SD_IDX: begin
                    ret_reg   <= ST_SD_IDXC;
                    state_reg <= ST_DIV_WAIT;
                end
                ST_SD_IDXC: begin
                    idx_reg   <= div_rsp.quot[PT_W-1:0];
                    rem_reg   <= div_rsp.rem[7:0];
                    state_reg <= ST_SD_T;
                end
                ST_SD_T: begin
                    ptw_reg   <= pt_q_reg;
                    slw_reg   <= sl_q_reg;
                    t_reg     <= rem_reg * pt_q_reg.dur;
                    state_reg <= ST_SD_TDIV;
                end
                ST_SD_TDIV: begin
                    ret_reg   <= ST_SD_STEPS;
                    state_reg <= ST_DIV_WAIT;
                end
                ST_SD_STEPS: begin
                    steps_reg <= div_rsp.quot[7:0];
                    k_reg     <= '0;
                    state_reg <= ST_SD_OFF;
                end
                ST_SD_OFF: begin
                    prod_reg  <= t_reg * sl_mag;
                    neg_reg   <= slw_reg[k_reg][16];
                    state_reg <= ST_SD_OFFDIV;
                end
                ST_SD_OFFDIV: begin
                    ret_reg   <= ST_SD_COL;
                    state_reg <= ST_DIV_WAIT;
                end
                ST_SD_COL: begin
                    logic signed [26:0] off;
                    off = $signed({2'b0, div_rsp.quot[24:0]});
                    led_reg.col[k_reg] <= clamp_col($signed({3'b0, ptw_reg.col[k_reg], 16'b0}
                                                    >>> 8) + (neg_reg ? -off : off));
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= (k_reg == 2'd2) ? ST_SD_WR : ST_SD_OFF;
                    led_reg.cur   <= idx_reg;
                    led_reg.steps <= steps_reg;
                end
                ST_SD_WR: begin
                    i_reg   <= i_reg + 9'd1;
                    pos_reg <= ({1'b0, pos_reg} + 9'd1 == per_reg) ? '0 : pos_reg + 8'd1;
                    state_reg <= (i_reg + 9'd1 == n_eff) ? ST_DONE : ST_SD_IDX;
                end

                // Tick: step every LED in use.
                ST_TK_RD: begin
                    state_reg <= ST_TK_LED;
                end
                ST_TK_LED: begin
                    led_reg   <= led_eff;
                    state_reg <= ST_TK_PT;
                end
                ST_TK_PT: begin
                    for (int k = 0; k < 3; k++) begin
                        logic [16:0] s;
                        s = tk_valid ? sl_q_reg[k] : 17'd0;
                        led_reg.col[k] <= clamp_col($signed({11'b0, led_reg.col[k]}) +
                                                    $signed({{10{s[16]}}, s}));
                    end
                    if (tk_roll) begin
                        led_reg.cur   <= tk_nxt;
                        led_reg.steps <= '0;
                        state_reg     <= ST_TK_NEXT;
                    end else begin
                        led_reg.steps <= led_reg.steps + 8'd1;
                        state_reg     <= ST_TK_WR;
                    end
                end
                ST_TK_NEXT: begin
                    for (int k = 0; k < 3; k++) begin
                        led_reg.col[k] <= {pt_q_reg.col[k], 8'b0};
                    end
                    state_reg <= ST_TK_WR;
                end
                ST_TK_WR: begin
                    i_reg     <= i_reg + 9'd1;
                    state_reg <= (i_reg + 9'd1 == n_eff) ? ST_DONE : ST_TK_RD;
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register: a finished result waits here while the next request runs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
            m_valid_reg  <= 1'b1;
            m_status_reg <= res_status_reg;
            m_data_reg   <= res_col_reg;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_data_reg;

    // The LED store is written only inside the LEDs in use.
    a_led_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        led_we |-> (i_reg < n_eff))
        else $error("LED store written beyond the LEDs in use");

    // The shared divider is never restarted while it works.
    a_div_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // A tick with no current wave completes without touching the store.
    a_tick_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tuser == KIND_TICK && !ready_reg) |=> (state_reg == ST_DONE))
        else $error("tick ran without a current wave");

endmodule

[hw/rtl/lwge_div.sv]
// Bit-serial restoring divider shared by slope, repetition length and seeding arithmetic.
module lwge_div
    import lwge_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]  num_reg;
    logic [DIV_W-1:0]  quot_reg;
    logic [8:0]        rem_reg;
    logic [8:0]        div_reg;
    logic [DIV_NW-1:0] cnt_reg;
    logic              busy_reg;
    logic [9:0]        trial;
    logic [9:0]        diff;

    // One quotient bit per cycle.
    assign trial = {rem_reg, num_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= req.nbits;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Operands are aligned so that the top bit of the used range leads.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg  <= req.dividend << (DIV_NW'(DIV_W) - req.nbits);
            quot_reg <= '0;
            rem_reg  <= '0;
            div_reg  <= req.divisor;
        end else if (busy_reg && cnt_reg != '0) begin
            num_reg <= {num_reg[DIV_W-2:0], 1'b0};
            if (!diff[9]) begin
                rem_reg  <= diff[8:0];
                quot_reg <= {quot_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_reg  <= trial[8:0];
                quot_reg <= {quot_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = busy_reg && (cnt_reg == '0);
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

[tb/sv/lwge_checker.sv]
// Checker for the LED wave gradient engine: predicts every result word and compares it.
`timescale 1ns / 100ps

module lwge_checker
    import lwge_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    // Predicted gradient state, in the block's own units.
    int pt_col [MAX_WAVES*MAX_POINTS][3];
    int pt_dur [MAX_WAVES*MAX_POINTS];
    int step_w [MAX_WAVES*MAX_POINTS][3];
    int shp_cnt [MAX_WAVES];
    int shp_wid [MAX_WAVES];
    int led_col [MAX_LEDS][3];
    int led_cur [MAX_LEDS];
    int led_steps [MAX_LEDS];
    int cur_wave;
    bit wave_live;
    int led_cfg;

    // Expected result words: {status, blue, green, red}.
    logic [24:0] result_q[$];

    assign pending = result_q.size();

    function automatic int leds_used();
        return led_cfg > MAX_LEDS ? MAX_LEDS : led_cfg;
    endfunction

    // Division rounded to nearest with ties away from zero.
    function automatic longint div_near(longint num, longint den);
        longint mag;
        longint q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic int clamp_col(longint v);
        if (v < 0) return 0;
        if (v > COLOUR_MAX) return COLOUR_MAX;
        return int'(v);
    endfunction

    // Computes step widths, makes the wave current and seeds every LED in use.
    function automatic void launch_wave(int w);
        int p;
        int base;
        int n;
        int nx;
        int width;
        int per;
        int num;
        int idx;
        int rem;
        longint off;
        p = shp_cnt[w];
        base = w * MAX_POINTS;
        n = leds_used();
        for (int i = 0; i < p; i++) begin
            nx = (i + 1 < p) ? i + 1 : 0;
            for (int k = 0; k < 3; k++) begin
                step_w[base+i][k] = pt_dur[base+i] == 0 ? 0 :
                    int'(div_near((pt_col[base+nx][k] - pt_col[base+i][k]) * 256,
                                  pt_dur[base+i]));
            end
        end
        cur_wave = w;
        wave_live = 1'b1;
        if (n == 0) return;
        width = shp_wid[w] > n ? n : shp_wid[w];
        per = n / (n / width);
        for (int i = 0; i < n; i++) begin
            num = (i % per) * p;
            idx = num / per;
            rem = num % per;
            for (int k = 0; k < 3; k++) begin
                off = longint'(rem) * pt_dur[base+idx] * step_w[base+idx][k];
                led_col[i][k] = clamp_col(longint'(pt_col[base+idx][k]) * 256
                                          + div_near(off, per));
            end
            led_cur[i] = idx;
            led_steps[i] = rem * pt_dur[base+idx] / per;
        end
    endfunction

    // One animation tick over every LED in use.
    function automatic void advance_leds();
        int n;
        int base;
        int p;
        int cur;
        int dur;
        int nx;
        bit ok;
        n = leds_used();
        base = cur_wave * MAX_POINTS;
        p = shp_cnt[cur_wave];
        if (!wave_live) return;
        for (int i = 0; i < n; i++) begin
            cur = led_cur[i];
            ok = cur < p;
            dur = ok ? pt_dur[base+cur] : 0;
            for (int k = 0; k < 3; k++) begin
                led_col[i][k] = clamp_col(longint'(led_col[i][k]) +
                                          (ok ? step_w[base+cur][k] : 0));
            end
            if (led_steps[i] + 1 >= dur) begin
                nx = (cur + 1 >= p) ? 0 : cur + 1;
                led_cur[i] = nx;
                led_steps[i] = 0;
                for (int k = 0; k < 3; k++) led_col[i][k] = pt_col[base+nx][k] * 256;
            end else begin
                led_steps[i]++;
            end
        end
    endfunction

    // Applies one request word and returns its expected result word.
    function automatic logic [24:0] apply_request(logic [2:0] kind, logic [63:0] d);
        int w;
        int pi;
        int pc;
        int ww;
        int dur;
        int li;
        int v;
        logic st;
        logic [7:0] col [3];
        w = d[1:0];
        pi = d[5:2];
        pc = d[10:6];
        ww = d[19:11];
        dur = d[51:44];
        li = d[59:52];
        st = STATUS_OK;
        col = '{8'd0, 8'd0, 8'd0};
        case (kind)
            KIND_DEFINE: begin
                if (pc == 0 || pc > MAX_POINTS || ww == 0 || ww > MAX_LEDS) begin
                    st = STATUS_BAD;
                end else begin
                    shp_cnt[w] = pc;
                    shp_wid[w] = ww;
                    if (w == cur_wave) wave_live = 1'b0;
                end
            end
            KIND_LOAD: begin
                if (shp_cnt[w] == 0 || pi >= shp_cnt[w] || dur == 0) begin
                    st = STATUS_BAD;
                end else begin
                    pt_col[w*MAX_POINTS+pi][0] = d[27:20];
                    pt_col[w*MAX_POINTS+pi][1] = d[35:28];
                    pt_col[w*MAX_POINTS+pi][2] = d[43:36];
                    pt_dur[w*MAX_POINTS+pi] = dur;
                    if (pi + 1 == shp_cnt[w]) launch_wave(w);
                end
            end
            KIND_START: begin
                if (shp_cnt[w] == 0) st = STATUS_BAD;
                else launch_wave(w);
            end
            KIND_TICK: advance_leds();
            KIND_READ: begin
                if (li >= leds_used()) begin
                    st = STATUS_BAD;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        v = (led_col[li][k] + 128) >> 8;
                        col[k] = v > 255 ? 8'd255 : v[7:0];
                    end
                end
            end
            default: st = STATUS_BAD;
        endcase
        return {st, col[2], col[1], col[0]};
    endfunction

    // Watch both channels and the register port.
    always @(posedge aclk) begin
        logic [24:0] want;
        if (!aresetn) begin
            foreach (shp_cnt[i]) begin
                shp_cnt[i] = 0;
                shp_wid[i] = 0;
            end
            foreach (led_col[i]) begin
                led_col[i] = '{0, 0, 0};
                led_cur[i] = 0;
                led_steps[i] = 0;
            end
            cur_wave = 0;
            wave_live = 1'b0;
            led_cfg = MAX_LEDS;
            fail_count = 0;
            result_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == {REG_LED_COUNT, 2'b00})
                led_cfg = pwdata[8:0];
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result word with nothing expected: status %0d rgb %h",
                                 $realtime, m_tuser, m_tdata);
                end else begin
                    want = result_q.pop_front();
                    if ({m_tuser, m_tdata} !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch status %0d/%0d red %0d/%0d ",
                                      "green %0d/%0d blue %0d/%0d (expected/actual)"},
                                     $realtime, want[24], m_tuser[0], want[7:0], m_tdata[7:0],
                                     want[15:8], m_tdata[15:8], want[23:16], m_tdata[23:16]);
                    end
                end
            end
            if (s_tvalid && s_tready) result_q.push_back(apply_request(s_tuser, s_tdata));
        end
    end

endmodule

[tb/sv/tb.sv]
// Testbench top for the LED wave gradient engine: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb;
    import lwge_pkg::*;

    localparam int IDLE_LIMIT = 200000;

    typedef struct {
        logic [1:0] w;
        logic [3:0] pi;
        logic [4:0] pc;
        logic [8:0] ww;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] dur;
        logic [7:0] li;
    } req_t;

    logic        aclk;
    logic        aresetn;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    // Sender bookkeeping: wave shapes and loaded points, so no unwritten point is used.
    int shape_cnt [MAX_WAVES];
    bit written [MAX_WAVES][MAX_POINTS];
    int burst_left;
    int led_cfg;
    int phase_items;
    logic long_hold;
    int idle_cycles;

    led_wave_gradient_engine i_dut (.*);

    lwge_checker i_checker (.*);

    always #1 aclk = ~aclk;

    // Receiver: stall pattern in segments, plus one long hold-off on request.
    int seg_left;
    int stall_mode;
    int hold_left;
    bit hold_done;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            seg_left = 0;
            hold_left = 0;
            hold_done = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (long_hold && !hold_done) begin
            hold_left = 3000;
            hold_done = 1;
            m_tready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 200);
                stall_mode = $urandom_range(0, 2);
            end
            seg_left--;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic bit points_loaded(int w, int except);
        for (int i = 0; i < shape_cnt[w]; i++)
            if (!written[w][i] && i != except) return 0;
        return 1;
    endfunction

    function automatic req_t rand_req();
        req_t q;
        q.w = $urandom;
        q.pi = $urandom;
        q.pc = $urandom;
        q.ww = $urandom;
        q.r = $urandom;
        q.g = $urandom;
        q.b = $urandom;
        q.dur = $urandom;
        q.li = $urandom;
        return q;
    endfunction

    function automatic logic [7:0] rand_col();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return $urandom;
        endcase
    endfunction

    // Sends one request word in the current burst, then updates the bookkeeping.
    task automatic send_req(logic [2:0] kind, req_t q);
        int gap;
        bit rdy;
        // A start over unloaded points is never caused; such a word becomes a tick.
        if (kind == KIND_LOAD && shape_cnt[q.w] != 0 && q.pi == shape_cnt[q.w] - 1 &&
            q.dur != 0 && !points_loaded(q.w, q.pi))
            kind = KIND_TICK;
        if (kind == KIND_START && shape_cnt[q.w] != 0 && !points_loaded(q.w, -1))
            kind = KIND_TICK;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 20);
        end
        burst_left--;
        s_tuser <= kind;
        s_tdata <= {4'b0, q.li, q.dur, q.b, q.g, q.r, q.ww, q.pc, q.pi, q.w};
        s_tvalid <= 1'b1;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        phase_items++;
        if (kind == KIND_DEFINE && q.pc != 0 && q.pc <= MAX_POINTS && q.ww != 0 &&
            q.ww <= MAX_LEDS)
            shape_cnt[q.w] = q.pc;
        if (kind == KIND_LOAD && shape_cnt[q.w] != 0 && q.pi < shape_cnt[q.w] && q.dur != 0)
            written[q.w][q.pi] = 1;
    endtask

    task automatic send_define(int w, int pc, int ww);
        req_t q;
        q = rand_req();
        q.w = w;
        q.pc = pc;
        q.ww = ww;
        send_req(KIND_DEFINE, q);
    endtask

    task automatic send_load(int w, int pi, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             int dur);
        req_t q;
        q = rand_req();
        q.w = w;
        q.pi = pi;
        q.r = r;
        q.g = g;
        q.b = b;
        q.dur = dur;
        send_req(KIND_LOAD, q);
    endtask

    task automatic send_read(int li);
        req_t q;
        q = rand_req();
        q.li = li;
        send_req(KIND_READ, q);
    endtask

    task automatic send_tick();
        send_req(KIND_TICK, rand_req());
    endtask

    // Waits until every expected result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_led_count(int value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_LED_COUNT, 2'b00};
        pwdata <= {$urandom, 9'd0} | value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        led_cfg = value;
    endtask

    task automatic random_read();
        if ($urandom_range(0, 5) == 0) send_read($urandom_range(0, 255));
        else send_read($urandom_range(0, led_cfg - 1));
    endtask

    // A well-formed wave program with random content, sometimes with noise inside.
    task automatic wave_program();
        int w;
        int pc;
        int ww;
        int dur;
        int n_after;
        w = $urandom_range(0, 3);
        pc = ($urandom_range(0, 7) == 0) ? MAX_POINTS : $urandom_range(1, 4);
        ww = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) :
             $urandom_range(1, led_cfg);
        send_define(w, pc, ww);
        for (int i = 0; i < pc; i++) begin
            case ($urandom_range(0, 9))
                0: dur = 255;
                1: dur = 1;
                2: dur = $urandom_range(1, 255);
                default: dur = $urandom_range(1, 8);
            endcase
            send_load(w, i, rand_col(), rand_col(), rand_col(), dur);
            if ($urandom_range(0, 9) == 0) send_req($urandom_range(0, 7), rand_req());
        end
        n_after = $urandom_range(0, 14);
        for (int i = 0; i < n_after; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_tick();
                5, 6, 7: random_read();
                8: send_req(KIND_START, rand_req());
                default: send_req($urandom_range(0, 7), rand_req());
            endcase
        end
    endtask

    int led_plan [] = '{7, 1, 16, 3, 256, 11, 5, 2, 9, 4, 13};

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        long_hold = 1'b0;
        burst_left = 0;
        led_cfg = MAX_LEDS;
        foreach (shape_cnt[i]) shape_cnt[i] = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: full strip, widest wave, extreme colors and durations, rejections.
        send_tick();
        send_define(0, 2, 256);
        send_load(0, 0, 8'd0, 8'd0, 8'd0, 255);
        send_load(0, 1, 8'd255, 8'd255, 8'd255, 1);
        send_tick();
        send_read(0);
        send_read(255);
        send_read(128);
        send_load(0, 0, 8'd9, 8'd9, 8'd9, 0);
        send_load(0, 5, 8'd9, 8'd9, 8'd9, 3);
        send_define(1, 0, 10);
        send_define(1, 17, 10);
        send_define(1, 31, 511);
        send_define(1, 4, 0);
        send_define(1, 4, 257);
        send_load(3, 0, 8'd1, 8'd2, 8'd3, 4);
        send_req(KIND_START, '{w: 2'd3, default: '0});
        for (int k = 5; k < 8; k++) send_req(k, rand_req());
        drain();

        // Directed: a single LED through a sixteen-point wave of width one.
        write_led_count(1);
        send_define(1, 16, 1);
        for (int i = 0; i < 16; i++)
            send_load(1, i, rand_col(), rand_col(), rand_col(), i == 15 ? 255 : i + 1);
        send_tick();
        send_tick();
        send_read(0);
        send_read(1);
        send_req(KIND_START, '{w: 2'd1, default: '0});
        send_define(1, 2, 1);
        send_tick();
        drain();

        // Random phases at several strip lengths.
        foreach (led_plan[p]) begin
            write_led_count(led_plan[p]);
            phase_items = 0;
            if (p == 2) begin
                long_hold <= 1'b1;
                for (int i = 0; i < 30; i++) random_read();
            end
            while (phase_items < (led_plan[p] > 64 ? 25 : 180)) wave_program();
            drain();
        end
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/lwge_pkg.sv
hw/rtl/lwge_div.sv
hw/rtl/led_wave_gradient_engine.sv
tb/sv/lwge_checker.sv
tb/sv/tb.sv
